// File: rtl/dssm_pkg.sv
// Package for the two-stack shared memory: payload types, command types and codes.
`timescale 1ns / 1ps
`default_nettype none
package dssm_pkg;

  localparam logic [2:0] ACT_PUSH_ONE = 3'd0;
  localparam logic [2:0] ACT_POP_ONE  = 3'd1;
  localparam logic [2:0] ACT_PUSH_TWO = 3'd2;
  localparam logic [2:0] ACT_POP_TWO  = 3'd3;
  localparam logic [2:0] ACT_LIST_ONE = 3'd4;
  localparam logic [2:0] ACT_LIST_TWO = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_LIST = 2'd2;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] word_out;
    logic [1:0]         status;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               upper;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
  } cmdq_status_t;

endpackage
`default_nettype wire

// File: rtl/dssm_front.sv
// Front end: accepts input transactions and decodes actions into stack commands.
`timescale 1ns / 1ps
`default_nettype none
module dssm_front import dssm_pkg::*; (
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire in_t          in_data,
  input  wire cmdq_status_t q_status,
  output logic              cmd_valid,
  output cmd_t              cmd
);

  logic known;

  always_comb begin
    known     = 1'b1;
    cmd.value = in_data.push_value;
    cmd.kind  = CMD_PUSH;
    cmd.upper = 1'b0;
    unique case (in_data.action)
      ACT_PUSH_ONE: begin cmd.kind = CMD_PUSH; cmd.upper = 1'b0; end
      ACT_POP_ONE:  begin cmd.kind = CMD_POP;  cmd.upper = 1'b0; end
      ACT_PUSH_TWO: begin cmd.kind = CMD_PUSH; cmd.upper = 1'b1; end
      ACT_POP_TWO:  begin cmd.kind = CMD_POP;  cmd.upper = 1'b1; end
      ACT_LIST_ONE: begin cmd.kind = CMD_LIST; cmd.upper = 1'b0; end
      ACT_LIST_TWO: begin cmd.kind = CMD_LIST; cmd.upper = 1'b1; end
      default:      known = 1'b0;
    endcase
  end

  // undefined actions are accepted and dropped
  assign in_stall  = q_status.full;
  assign cmd_valid = in_valid && !q_status.full && known;

endmodule
`default_nettype wire

// File: rtl/dssm_cmdq.sv
// Short command queue between the front end and the stack engine.
`timescale 1ns / 1ps
`default_nettype none
module dssm_cmdq import dssm_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire cmd_t   push_cmd,
  input  wire logic   take,
  output logic        head_valid,
  output cmd_t        head_cmd,
  output cmdq_status_t status
);

  cmd_t                 entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wptr;
  logic [CMDQ_AW-1:0]   rptr;
  logic [CMDQ_AW:0]     fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (take) rptr <= rptr + 1'b1;
      if (push && !take)      fill <= fill + 1'b1;
      else if (take && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_cmd;
  end

  assign head_valid   = (fill != '0);
  assign head_cmd     = entries[rptr];
  assign status.full  = (fill == (CMDQ_AW + 1)'(CMDQ_DEPTH));

endmodule
`default_nettype wire

// File: rtl/dssm_back.sv
// Stack engine: shared memory, stack counts and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none
module dssm_back import dssm_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_take,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;

  logic          state, state_next;
  logic [CW-1:0] lower, lower_next;
  logic [CW-1:0] upper, upper_next;
  logic [CW-1:0] remain, remain_next;
  logic [AW-1:0] ptr, ptr_next;
  logic          dir, dir_next;
  logic          out_valid_next;
  out_t          out_data_next;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW:0]   used;
  logic          full, stk_empty, out_free;
  logic [CW-1:0] top_lo, top_up, push_up;
  logic [AW-1:0] ptr_adv;

  assign used      = {1'b0, lower} + {1'b0, upper};
  assign full      = (used >= (CW + 1)'(DEPTH));
  assign stk_empty = q_cmd.upper ? (upper == '0) : (lower == '0);
  assign out_free  = !out_valid || !out_stall;
  assign top_lo    = lower - CW'(1);
  assign top_up    = DEPTH_C - upper;
  assign push_up   = DEPTH_C - CW'(1) - upper;
  assign ptr_adv   = dir ? ptr + 1'b1 : ptr - 1'b1;

  always_comb begin
    state_next     = state;
    lower_next     = lower;
    upper_next     = upper;
    remain_next    = remain;
    ptr_next       = ptr;
    dir_next       = dir;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    rd_en          = 1'b0;
    rd_addr        = ptr;
    wr_en          = 1'b0;
    wr_addr        = lower[AW-1:0];
    q_take         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_take = 1'b1;
          unique case (q_cmd.kind)
            CMD_PUSH: begin
              out_valid_next = 1'b1;
              out_data_next  = '{word_out: '0, status: full ? ST_FULL : ST_OK, last: 1'b1};
              if (!full) begin
                wr_en = 1'b1;
                if (q_cmd.upper) begin
                  wr_addr    = push_up[AW-1:0];
                  upper_next = upper + CW'(1);
                end else begin
                  wr_addr    = lower[AW-1:0];
                  lower_next = lower + CW'(1);
                end
              end
            end
            CMD_POP, CMD_LIST: begin
              if (stk_empty) begin
                out_valid_next = 1'b1;
                out_data_next  = '{word_out: '0, status: ST_EMPTY, last: 1'b1};
              end else begin
                rd_en      = 1'b1;
                rd_addr    = q_cmd.upper ? top_up[AW-1:0] : top_lo[AW-1:0];
                ptr_next   = rd_addr;
                dir_next   = q_cmd.upper;
                state_next = S_RD;
                if (q_cmd.kind == CMD_POP) begin
                  remain_next = CW'(1);
                  if (q_cmd.upper) upper_next = upper - CW'(1);
                  else             lower_next = top_lo;
                end else begin
                  remain_next = q_cmd.upper ? upper : lower;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '{word_out: rd_data, status: ST_OK, last: remain == CW'(1)};
          if (remain == CW'(1)) begin
            state_next = S_IDLE;
          end else begin
            remain_next = remain - CW'(1);
            ptr_next    = ptr_adv;
            rd_en       = 1'b1;
            rd_addr     = ptr_adv;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lower     <= '0;
      upper     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lower     <= lower_next;
      upper     <= upper_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    remain   <= remain_next;
    ptr      <= ptr_next;
    dir      <= dir_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= q_cmd.value;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used <= (CW + 1)'(DEPTH))
    else $error("stack counts exceed depth");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    q_take && q_cmd.kind == CMD_PUSH && full |=> $stable(lower) && $stable(upper))
    else $error("refused push changed a stack count");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.word_out == '0 && out_data.last)
    else $error("error result carries data or is not last");

  a_rd_remain: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> remain != '0 && !q_take)
    else $error("read state with nothing left or taking commands");

endmodule
`default_nettype wire

// File: rtl/dual_stack_shared_memory.sv
// Top level: two stacks sharing one memory, front decoder, command queue, stack engine.
// Push transactions: the engine writes memory and registers the result as it takes the command.
// Pop: issue, then a registered memory read; list: the read state returns each entry in turn.
// The command queue keeps accepting input while a result waits in the output register, until it is full.
// Reset (rst, synchronous, active high) clears both stack counts, the queue and the
// output valid; memory contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module dual_stack_shared_memory import dssm_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  cmdq_status_t q_status;
  logic         cmd_valid;
  cmd_t         cmd;
  logic         q_valid;
  cmd_t         q_cmd;
  logic         q_take;

  dssm_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  dssm_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .take       (q_take),
    .head_valid (q_valid),
    .head_cmd   (q_cmd),
    .status     (q_status)
  );

  dssm_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: tb/sv/tb_dual_stack_shared_memory.sv
// Testbench for dual_stack_shared_memory: directed and random stack traffic vs. a predictor.
`timescale 1ns / 1ps
module tb_dual_stack_shared_memory;
  import dssm_pkg::*;

  localparam int STACK_WORDS = 16;
  localparam int TAIL_CYCLES = 64;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] ACT_UNUSED_A = 3'd6;
  localparam logic [2:0] ACT_UNUSED_B = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic signed [31:0] shared_words [STACK_WORDS];
  int   low_count = 0;
  int   high_count = 0;
  out_t awaited_results [$];
  int   mismatch_count = 0;
  bit   sender_burst = 1'b0;
  bit   receiver_burst = 1'b0;

  dual_stack_shared_memory #(.DEPTH(STACK_WORDS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic signed [31:0] draw_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // Expected results of one accepted transaction; updates the stack model.
  function automatic void predict_stack_results(in_t item);
    out_t res;
    int   used;
    int   idx;
    used = low_count + high_count;
    res.word_out = '0;
    res.status = ST_OK;
    res.last = 1'b1;
    case (item.action)
      ACT_PUSH_ONE: begin
        if (used < STACK_WORDS) begin
          shared_words[low_count] = item.push_value;
          low_count++;
        end else begin
          res.status = ST_FULL;
        end
        awaited_results.push_back(res);
      end
      ACT_PUSH_TWO: begin
        if (used < STACK_WORDS) begin
          high_count++;
          shared_words[STACK_WORDS - high_count] = item.push_value;
        end else begin
          res.status = ST_FULL;
        end
        awaited_results.push_back(res);
      end
      ACT_POP_ONE: begin
        if (low_count > 0) begin
          low_count--;
          res.word_out = shared_words[low_count];
        end else begin
          res.status = ST_EMPTY;
        end
        awaited_results.push_back(res);
      end
      ACT_POP_TWO: begin
        if (high_count > 0) begin
          res.word_out = shared_words[STACK_WORDS - high_count];
          high_count--;
        end else begin
          res.status = ST_EMPTY;
        end
        awaited_results.push_back(res);
      end
      ACT_LIST_ONE: begin
        if (low_count == 0) begin
          res.status = ST_EMPTY;
          awaited_results.push_back(res);
        end else begin
          for (idx = low_count - 1; idx >= 0; idx--) begin
            res.word_out = shared_words[idx];
            res.last = (idx == 0);
            awaited_results.push_back(res);
          end
        end
      end
      ACT_LIST_TWO: begin
        if (high_count == 0) begin
          res.status = ST_EMPTY;
          awaited_results.push_back(res);
        end else begin
          for (idx = STACK_WORDS - high_count; idx < STACK_WORDS; idx++) begin
            res.word_out = shared_words[idx];
            res.last = (idx == STACK_WORDS - 1);
            awaited_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [2:0] act, logic signed [31:0] value);
    in_t item;
    int  gap;
    item.action = act;
    item.push_value = value;
    gap = draw_gap(sender_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_stack_results(item);
  endtask

  // Hold off new transactions until every predicted result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic test_empty_stacks();
    send_item(ACT_POP_ONE, draw_word());
    send_item(ACT_POP_TWO, draw_word());
    send_item(ACT_LIST_ONE, draw_word());
    send_item(ACT_LIST_TWO, draw_word());
  endtask

  task automatic test_extreme_words();
    send_item(ACT_PUSH_ONE, 32'sh7FFF_FFFF);
    send_item(ACT_PUSH_ONE, 32'sh8000_0000);
    send_item(ACT_PUSH_TWO, -32'sd1);
    send_item(ACT_PUSH_TWO, 32'sd0);
    send_item(ACT_UNUSED_A, 32'sh5555_5555);
    send_item(ACT_UNUSED_B, 32'shAAAA_AAAA);
    send_item(ACT_POP_ONE, 32'sd0);
    send_item(ACT_POP_TWO, 32'sd0);
  endtask

  task automatic test_full_memory();
    int n;
    for (n = 0; n < 7; n++) begin
      send_item(ACT_PUSH_ONE, draw_word());
      send_item(ACT_PUSH_TWO, draw_word());
    end
    send_item(ACT_PUSH_ONE, 32'sh1234_5678);
    send_item(ACT_PUSH_TWO, 32'sh1234_5678);
    send_item(ACT_LIST_ONE, 32'sd0);
    send_item(ACT_LIST_TWO, 32'sd0);
  endtask

  // Fill/drain phases with mostly push/pop, some lists and a little noise.
  task automatic test_random_traffic(int count);
    int         sent;
    int         step;
    int         pick;
    bit         fill_phase;
    logic [2:0] act;
    sent = 0;
    step = 0;
    fill_phase = 1'b1;
    while (sent < count) begin
      if (step % 32 == 0) begin
        fill_phase = $urandom_range(0, 1);
        sender_burst = ($urandom_range(0, 2) == 0);
        receiver_burst = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        act = $urandom_range(0, 1) ? ACT_UNUSED_A : ACT_UNUSED_B;
      end else if (pick < 12) begin
        act = $urandom_range(0, 1) ? ACT_LIST_ONE : ACT_LIST_TWO;
      end else if ($urandom_range(0, 99) < (fill_phase ? 75 : 25)) begin
        act = $urandom_range(0, 1) ? ACT_PUSH_ONE : ACT_PUSH_TWO;
      end else begin
        act = $urandom_range(0, 1) ? ACT_POP_ONE : ACT_POP_TWO;
      end
      send_item(act, draw_word());
      if (act != ACT_UNUSED_A && act != ACT_UNUSED_B) sent++;
      step++;
      if (step == 200) wait_drained();
    end
  endtask

  initial begin : result_checker
    int   hold;
    out_t want;
    forever begin
      hold = draw_gap(receiver_burst);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid === 1'b1 && !rst)) @(posedge clk);
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected transaction: word %0d status %0d last %0b",
                               out_data.word_out, out_data.status, out_data.last));
      end else begin
        want = awaited_results.pop_front();
        if (out_data.word_out !== want.word_out)
          note_failure($sformatf("word_out mismatch: expected %0d actual %0d",
                                 want.word_out, out_data.word_out));
        if (out_data.status !== want.status)
          note_failure($sformatf("status mismatch: expected %0d actual %0d",
                                 want.status, out_data.status));
        if (out_data.last !== want.last)
          note_failure($sformatf("last mismatch: expected %0b actual %0b",
                                 want.last, out_data.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("dual_stack_shared_memory verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_stacks();
    test_extreme_words();
    test_full_memory();
    wait_drained();
    test_random_traffic(370);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("dual_stack_shared_memory verification clean");
    end else begin
      $display("dual_stack_shared_memory verification failed");
    end
    $finish;
  end

endmodule
